### hdl/bcc_pkg.sv
// Shared widths, constants and codes for the button click classifier.
// No dependencies; used by button_click_classifier_core.
package bcc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned LongW     = 16;
  localparam int unsigned WindowW   = 10;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TimeW-1:0]   RepeatHoldMs  = TimeW'(700);
  localparam logic [WindowW-1:0] WindowResetMs = WindowW'(280);

  typedef enum logic [EventW-1:0] {
    EvNone   = 3'd0,
    EvClick  = 3'd1,
    EvDouble = 3'd2,
    EvTriple = 3'd3,
    EvLong   = 3'd4
  } event_code_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgAnalogThreshold = 2'd0,
    CfgInvertLevel     = 2'd1,
    CfgLongPressMs     = 2'd2,
    CfgWindowMs        = 2'd3
  } cfg_index_e;

  typedef enum logic {
    OpPoll   = 1'b0,
    OpCancel = 1'b1
  } op_e;

endpackage

### hdl/button_click_classifier_core.sv
// Button click classifier: input register, one pass of classify logic, result register.
// Depends on bcc_pkg for widths, constants and event codes.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) moves one request: an operation
//   (poll or cancel), a millisecond time stamp, a pin sample, an edge flag
//   and a repeat enable. Output channel (out_valid_o / out_stall_i) moves
//   one result per request: event_code_o (none, click, double, triple, long).
//   A request is taken at a rising edge with valid high and stall low.
// Flow: the request lands in the input register when it is accepted, and
//   the result register loads from it at the first edge at which the
//   result register is free (empty, or its result taken). Throughput: one
//   request per cycle while the receiver does not stall; the single
//   classify pass reads and updates the button state in the same cycle.
// Stall: while the receiver stalls, the result register holds; the input
//   register still fills once, after which in_stall_o rises until the
//   result is taken. in_stall_o follows out_stall_i combinationally.
// Reset (rst_ni low, asynchronous): both registers empty, all button state
//   cleared, registers at their defaults (digital mode, window 280 ms,
//   long press off).
// Configuration: cfg_we_i writes register cfg_index_i at once; write only
//   while no request is in flight. Writing the threshold or the inversion
//   reseeds the remembered level to the idle level of the new mode.
module button_click_classifier_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [bcc_pkg::TimeW-1:0]          now_ms_i,
  input  logic [bcc_pkg::SampleW-1:0]        pin_sample_i,
  input  logic                               edge_seen_i,
  input  logic                               repeat_enable_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bcc_pkg::EventW-1:0]         event_code_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bcc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0]       cfg_data_i
);

  // configuration registers
  logic [bcc_pkg::SampleW-1:0] threshold_q;
  logic                        invert_q;
  logic [bcc_pkg::LongW-1:0]   long_ms_q;
  logic [bcc_pkg::WindowW-1:0] window_q;

  // input register
  logic                        in_valid_q;
  logic                        op_q;
  logic [bcc_pkg::TimeW-1:0]   now_q;
  logic [bcc_pkg::SampleW-1:0] sample_q;
  logic                        edge_q;
  logic                        repeat_q;

  // result register
  logic                        out_valid_q;
  bcc_pkg::event_code_e        event_q;

  // button state
  logic                        last_level_q, last_level_d;
  logic                        press_active_q, press_active_d;
  logic [bcc_pkg::TimeW-1:0]   press_start_q, press_start_d;
  logic                        cancel_hold_q, cancel_hold_d;
  logic [1:0]                  tally_q, tally_d;
  logic [bcc_pkg::TimeW-1:0]   last_click_q, last_click_d;
  logic                        pending_q, pending_d;
  bcc_pkg::event_code_e        event_d;

  logic advance;   // result register free: the held request moves on
  logic process;   // a held request is classified this cycle

  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

  // ---------------------------------------------------------------------
  // Classify pass: steps run in order, each seeing the previous step's
  // updates, so a fresh press start or click time gives a zero age.
  // ---------------------------------------------------------------------
  always_comb begin
    logic                      level;
    logic                      pressed;
    logic [bcc_pkg::TimeW-1:0] held_ms;
    logic [bcc_pkg::TimeW-1:0] quiet_ms;

    last_level_d   = last_level_q;
    press_active_d = press_active_q;
    press_start_d  = press_start_q;
    cancel_hold_d  = cancel_hold_q;
    tally_d        = tally_q;
    last_click_d   = last_click_q;
    pending_d      = pending_q;
    event_d        = bcc_pkg::EvNone;
    held_ms        = '0;
    quiet_ms       = '0;

    if (threshold_q != '0) begin
      level   = (sample_q < threshold_q);
      pressed = level;
    end else begin
      level   = sample_q[0];
      pressed = invert_q ? !level : level;
    end

    if (op_q == bcc_pkg::OpCancel) begin
      // cancel: drop the press and all pending clicks, block until release
      cancel_hold_d  = 1'b1;
      press_active_d = 1'b0;
      tally_d        = '0;
      last_click_d   = '0;
      pending_d      = 1'b0;
    end else begin
      // an edge caught between polls with the button up, no press active and no cancel hold, is a click
      if (edge_q && !pressed && !press_active_d && !cancel_hold_d) begin
        tally_d      = (tally_d == 2'd3) ? tally_d : tally_d + 2'd1;
        last_click_d = now_q;
        pending_d    = 1'b1;
      end

      if (level != last_level_d) begin
        if (pressed) begin
          press_active_d = 1'b1;
          press_start_d  = now_q;
        end else begin
          // release: short press is a click; with long press off, always
          if (long_ms_q == '0 ||
              (press_active_d && ((now_q - press_start_d) < {16'd0, long_ms_q}))) begin
            tally_d      = (tally_d == 2'd3) ? tally_d : tally_d + 2'd1;
            last_click_d = now_q;
            pending_d    = 1'b1;
          end
          press_active_d = 1'b0;
        end
        last_level_d = level;
      end

      if (!pressed) begin
        cancel_hold_d = 1'b0;
      end

      held_ms = now_q - press_start_d;

      if (long_ms_q != '0 && press_active_d && held_ms >= {16'd0, long_ms_q}) begin
        // long press with clicks pending acts as a cancel
        if (pending_d) begin
          cancel_hold_d = 1'b1;
        end else begin
          event_d = bcc_pkg::EvLong;
        end
        press_active_d = 1'b0;
        tally_d        = '0;
        last_click_d   = '0;
        pending_d      = 1'b0;
      end

      if (press_active_d && repeat_q && held_ms >= bcc_pkg::RepeatHoldMs) begin
        event_d = bcc_pkg::EvClick;
      end

      quiet_ms = now_q - last_click_d;
      if (pending_d && quiet_ms >= {22'd0, window_q} && !press_active_d) begin
        unique case (tally_d)
          2'd1:    event_d = bcc_pkg::EvClick;
          2'd2:    event_d = bcc_pkg::EvDouble;
          default: event_d = bcc_pkg::EvTriple;
        endcase
        tally_d      = '0;
        last_click_d = '0;
        pending_d    = 1'b0;
      end
    end
  end

  // input register: load whenever it is empty or its request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q     <= operation_i;
      now_q    <= now_ms_i;
      sample_q <= pin_sample_i;
      edge_q   <= edge_seen_i;
      repeat_q <= repeat_enable_i;
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      event_q     <= bcc_pkg::EvNone;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        event_q <= event_d;
      end
    end
  end

  // configuration and button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= '0;
      invert_q       <= 1'b0;
      long_ms_q      <= '0;
      window_q       <= bcc_pkg::WindowResetMs;
      last_level_q   <= 1'b0;
      press_active_q <= 1'b0;
      press_start_q  <= '0;
      cancel_hold_q  <= 1'b0;
      tally_q        <= '0;
      last_click_q   <= '0;
      pending_q      <= 1'b0;
    end else if (process) begin
      last_level_q   <= last_level_d;
      press_active_q <= press_active_d;
      press_start_q  <= press_start_d;
      cancel_hold_q  <= cancel_hold_d;
      tally_q        <= tally_d;
      last_click_q   <= last_click_d;
      pending_q      <= pending_d;
    end else if (cfg_we_i) begin
      unique case (bcc_pkg::cfg_index_e'(cfg_index_i))
        bcc_pkg::CfgAnalogThreshold: begin
          threshold_q  <= cfg_data_i[bcc_pkg::SampleW-1:0];
          // reseed to the idle level of the new mode
          last_level_q <= (cfg_data_i[bcc_pkg::SampleW-1:0] == '0) && invert_q;
        end
        bcc_pkg::CfgInvertLevel: begin
          invert_q     <= cfg_data_i[0];
          last_level_q <= (threshold_q == '0) && cfg_data_i[0];
        end
        bcc_pkg::CfgLongPressMs: begin
          long_ms_q <= cfg_data_i[bcc_pkg::LongW-1:0];
        end
        bcc_pkg::CfgWindowMs: begin
          window_q <= cfg_data_i[bcc_pkg::WindowW-1:0];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pending_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == (tally_q != 2'd0))
    else $error("click pending flag and tally disagree");

  a_cancel_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && op_q == bcc_pkg::OpCancel
      |=> cancel_hold_q && !press_active_q && !pending_q && out_valid_q
          && event_q == bcc_pkg::EvNone)
    else $error("cancel left state or reported an event");

  a_long_ends_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && event_d == bcc_pkg::EvLong |=> !press_active_q && !pending_q)
    else $error("long press left the press or clicks active");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while the pipeline could move");

endmodule
